FILE: rtl/terminal_line_editor_assert.svh
// Assertion macros for the terminal line editor.
// Each macro is clocked on clk and disabled while rst is high.
`ifndef TERMINAL_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("terminal_line_editor: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("terminal_line_editor: next-cycle check failed");

`endif

FILE: rtl/tle_pkg.sv
package tle_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [8:0] cap_t;

  // Largest line buffer supported, terminator included.
  localparam int unsigned MAX_LINE = 256;
  localparam int unsigned CAP_LIMIT = (MAX_LINE > 256) ? 256 : MAX_LINE;
  localparam cap_t CAP_MAX = cap_t'(CAP_LIMIT);
  localparam cap_t CAP_RESET = 9'd64;

  localparam byte_t CH_CR  = 8'h0D;
  localparam byte_t CH_LF  = 8'h0A;
  localparam byte_t CH_DEL = 8'h7F;
  localparam byte_t CH_BS  = 8'h08;
  localparam byte_t CH_SP  = 8'h20;
  localparam byte_t CH_NUL = 8'h00;

  // Buffer position kept for the terminator in a full line; characters are
  // stored only at positions below it.
  function automatic byte_t store_limit(input cap_t cap);
    cap_t c;
    c = cap;
    if (c > CAP_MAX) begin
      c = CAP_MAX;
    end
    if (c == 9'd0) begin
      c = 9'd1;
    end
    c = c - 9'd1;
    return c[7:0];
  endfunction

endpackage

FILE: rtl/terminal_line_editor.sv
// Channel  | Signals                          | Direction | Request moves
// ---------+----------------------------------+-----------+-----------------------------
// input    | in_valid, in_stall, rx_char      | in        | one received character
// output   | out_valid, out_stall, echo_*,    | out       | one echo/buffer-write result
//          | write_*, line_done, line_length, |           |
//          | last                             |           |
// config   | cfg_write, cfg_data              | in        | line_capacity, no wait
//
// A character produces one result per cycle unless out_stall holds the output: plain bytes
// give one result, line ends two and erases three, issued in turn by the result sequencer.
// An erase at position zero produces nothing and frees the slot without waiting on the output.
// A new character is taken in the cycle the previous one issues its last result.
// rst is synchronous and active high; it clears the cursor, the sequencer and
// the output register, and sets the capacity to 64.
// out_stall holds the output register and, through it, the sequencer.
`include "terminal_line_editor_assert.svh"

module terminal_line_editor (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  tle_pkg::cap_t   cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  tle_pkg::byte_t  rx_char,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            echo_valid,
  output tle_pkg::byte_t  echo_char,
  output logic            write_valid,
  output tle_pkg::byte_t  write_addr,
  output tle_pkg::byte_t  write_data,
  output logic            line_done,
  output tle_pkg::byte_t  line_length,
  output logic            last
);
  import tle_pkg::*;

  // Configuration and line state.
  cap_t  line_capacity;
  byte_t cursor_index;
  byte_t cursor_index_next;

  // The character being worked on and which of its results comes next.
  logic       held_full;
  byte_t      held_char;
  logic [1:0] held_step;

  byte_t limit;
  logic  is_eol;
  logic  is_erase;
  logic  can_store;
  logic  drop;
  logic  step_last;
  logic  out_free;
  logic  gen_fire;
  logic  held_done;
  logic  accept;
  byte_t eol_pos;

  // Fields of the result that the sequencer offers this cycle.
  byte_t echo_char_next;
  logic  write_valid_next;
  byte_t write_addr_next;
  byte_t write_data_next;
  logic  line_done_next;
  byte_t line_length_next;

  assign limit     = store_limit(line_capacity);
  assign is_eol    = held_char inside {CH_CR, CH_LF};
  assign is_erase  = held_char inside {CH_DEL, CH_BS};
  assign can_store = cursor_index < limit;
  // When the capacity was lowered below the cursor, the terminator and the
  // reported length saturate to the last legal position.
  assign eol_pos   = (cursor_index > limit) ? limit : cursor_index;

  // An erase at the start of the line is dropped without touching the output.
  assign drop      = held_full && is_erase && (cursor_index == CH_NUL);
  assign out_free  = !out_valid || !out_stall;
  assign gen_fire  = held_full && !drop && out_free;

  always_comb begin
    if (is_eol) begin
      step_last = held_step == 2'd1;
    end else if (is_erase) begin
      step_last = held_step == 2'd2;
    end else begin
      step_last = 1'b1;
    end
  end

  assign held_done = drop || (gen_fire && step_last);
  // The slot frees in the cycle its last result is issued, so the next
  // character can be taken at the same edge.
  assign in_stall  = held_full && !held_done;
  assign accept    = in_valid && !in_stall;

  // Result generation for the current step of the held character.
  always_comb begin
    echo_char_next   = held_char;
    write_valid_next = 1'b0;
    write_addr_next  = CH_NUL;
    write_data_next  = CH_NUL;
    line_done_next   = 1'b0;
    line_length_next = CH_NUL;
    if (is_eol) begin
      if (held_step == 2'd0) begin
        echo_char_next = CH_CR;
      end else begin
        // Second result: echo LF and write the terminator.
        echo_char_next   = CH_LF;
        write_valid_next = 1'b1;
        write_addr_next  = eol_pos;
        write_data_next  = CH_NUL;
        line_done_next   = 1'b1;
        line_length_next = eol_pos;
      end
    end else if (is_erase) begin
      // Erase on the terminal with BS, space, BS.
      echo_char_next = (held_step == 2'd1) ? CH_SP : CH_BS;
    end else if (can_store) begin
      write_valid_next = 1'b1;
      write_addr_next  = cursor_index;
      write_data_next  = held_char;
    end
  end

  // The cursor moves only when a character is finished, so every result of
  // that character sees the position it started with.
  always_comb begin
    cursor_index_next = cursor_index;
    if (held_done) begin
      if (is_eol) begin
        cursor_index_next = CH_NUL;
      end else if (is_erase) begin
        if (!drop) begin
          cursor_index_next = cursor_index - 8'd1;
        end
      end else if (can_store) begin
        cursor_index_next = cursor_index + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_capacity <= CAP_RESET;
      cursor_index  <= CH_NUL;
      held_full     <= 1'b0;
      held_step     <= 2'd0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        line_capacity <= cfg_data;
      end
      cursor_index <= cursor_index_next;
      if (accept) begin
        held_full <= 1'b1;
      end else if (held_done) begin
        held_full <= 1'b0;
      end
      if (held_done) begin
        held_step <= 2'd0;
      end else if (gen_fire) begin
        held_step <= held_step + 2'd1;
      end
      if (gen_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_char <= rx_char;
    end
    if (gen_fire) begin
      echo_valid  <= 1'b1;
      echo_char   <= echo_char_next;
      write_valid <= write_valid_next;
      write_addr  <= write_addr_next;
      write_data  <= write_data_next;
      line_done   <= line_done_next;
      line_length <= line_length_next;
      last        <= step_last;
    end
  end

  // A result that is not the last of its character always has more behind it.
  `TLE_ASSERT_SAME(a_more_pending, out_valid && !last, held_full)
  // A finished line always carries its terminator write and closes the character.
  `TLE_ASSERT_SAME(a_done_has_term, out_valid && line_done,
    write_valid && write_data == CH_NUL && last && echo_char == CH_LF)
  // A finished line end leaves the cursor at the start of the line.
  `TLE_ASSERT_NEXT(a_eol_clears, held_done && is_eol, cursor_index == CH_NUL)
  // A dropped erase never reaches the output register.
  `TLE_ASSERT_SAME(a_drop_silent, drop, !gen_fire)

endmodule
